@@ hdl/rdq_pkg.sv @@
// shared types and constants for the ring deque with indexed read
`timescale 1ns / 1ps
package rdq_pkg;

  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int FILL_W   = 5;
  localparam int STAT_W   = 2;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 104;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ       = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHR  = 2'd1,
    CELL_SHL  = 2'd2,
    CELL_LOAD = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hit;
  } cell_ctrl_t;

endpackage

@@ hdl/ring_deque_with_index_read.sv @@
// top level of the ring deque with indexed read
`timescale 1ns / 1ps
// Double-ended queue of DEPTH elements kept in a row of cells, logical index i
// in cell i. Input beats on s_*: s_tuser carries the operation (push back,
// push front, pop front, pop back, indexed read), s_tdata the element and the
// read position. Every input beat gives one output beat on m_*: read data,
// front and back elements, fill count and status after the operation.
// A push front shifts the row one cell towards the back, a pop front shifts it
// towards the front, a push back loads the cell at the fill count.
// The cells update at the accepting edge; the result is then gathered from
// the cells into the output register, which raises m_tvalid, as soon as the
// output register is free. One item is in work at a time: an item passes its
// update and the gather over the cells before the next one is taken.
// Reset clears the fill count and the handshake state; cell contents stay
// undefined until written. When the receiver stalls the result waits in the
// output register, the next item is still taken and held after its update
// until the output register frees; s_tready then stays low.
module ring_deque_with_index_read #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // data_in [31:0], position [35:32], zero fill
  input  logic [rdq_pkg::S_TDATA_W-1:0]  s_tdata,
  // kind [2:0]
  input  logic [rdq_pkg::KIND_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // read_data [31:0], front_elem [63:32], back_elem [95:64], fill_count [100:96],
  // status [102:101], zero fill
  output logic [rdq_pkg::M_TDATA_W-1:0]  m_tdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > rdq_pkg::POS_W) ? CNT_W : rdq_pkg::POS_W;

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic                        calc_valid;
  rdq_pkg::kind_t              calc_kind;
  rdq_pkg::status_t            calc_status;
  logic [rdq_pkg::POS_W-1:0]   calc_pos;

  logic                        accept;
  logic                        out_load;
  rdq_pkg::kind_t              in_kind;
  logic [rdq_pkg::POS_W-1:0]   in_pos;
  logic [ELEM_WIDTH-1:0]       din;
  rdq_pkg::cell_op_t           op;
  rdq_pkg::status_t            st;
  logic                        full;
  logic                        empty;

  logic [ELEM_WIDTH-1:0]       cell_q [DEPTH];
  logic [DEPTH-1:0]            rd_hit;
  logic [DEPTH-1:0]            back_hit;
  logic [ELEM_WIDTH-1:0]       rd_acc;
  logic [ELEM_WIDTH-1:0]       back_acc;
  logic [ELEM_WIDTH-1:0]       front_val;
  logic                        read_ok;
  logic [rdq_pkg::M_TDATA_W-1:0] m_tdata_next;

  assign s_tready = !calc_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_load = calc_valid && (!m_tvalid || m_tready);

  assign in_kind = rdq_pkg::kind_t'(s_tuser);
  assign in_pos  = s_tdata[35:32];
  assign din     = ELEM_WIDTH'(s_tdata[31:0]);
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);

  // operation decode
  always_comb begin
    op         = rdq_pkg::CELL_HOLD;
    st         = rdq_pkg::STAT_OK;
    count_next = count;
    case (in_kind)
      rdq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          st = rdq_pkg::STAT_FULL;
        end else begin
          op         = rdq_pkg::CELL_LOAD;
          count_next = count + 1'b1;
        end
      end
      rdq_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          st = rdq_pkg::STAT_FULL;
        end else begin
          op         = rdq_pkg::CELL_SHR;
          count_next = count + 1'b1;
        end
      end
      rdq_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          st = rdq_pkg::STAT_EMPTY;
        end else begin
          op         = rdq_pkg::CELL_SHL;
          count_next = count - 1'b1;
        end
      end
      rdq_pkg::KIND_POP_BACK: begin
        if (empty) begin
          st = rdq_pkg::STAT_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      rdq_pkg::KIND_READ: begin
        if (CMP_W'(in_pos) >= CMP_W'(count)) begin
          st = rdq_pkg::STAT_RANGE;
        end
      end
      default: begin
        st = rdq_pkg::STAT_OK;
      end
    endcase
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rdq_pkg::cell_ctrl_t     ctrl;
    logic [ELEM_WIDTH-1:0]   left;
    logic [ELEM_WIDTH-1:0]   right;

    assign ctrl.op  = accept ? op : rdq_pkg::CELL_HOLD;
    assign ctrl.hit = (count == CNT_W'(i));

    if (i == 0) begin : g_first
      assign left = din;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end

    rdq_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .din   (din),
      .q     (cell_q[i])
    );

    assign rd_hit[i]   = read_ok && (CMP_W'(calc_pos) == CMP_W'(i));
    assign back_hit[i] = (count == CNT_W'(i + 1));
  end

  assign read_ok = (calc_kind == rdq_pkg::KIND_READ) && (calc_status == rdq_pkg::STAT_OK);

  // gather from the cells after the update
  always_comb begin
    rd_acc   = '0;
    back_acc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_acc   = rd_acc | (cell_q[i] & {ELEM_WIDTH{rd_hit[i]}});
      back_acc = back_acc | (cell_q[i] & {ELEM_WIDTH{back_hit[i]}});
    end
  end

  assign front_val = empty ? '0 : cell_q[0];

  assign m_tdata_next = {1'b0,
                         calc_status,
                         rdq_pkg::FILL_W'(count),
                         rdq_pkg::DATA_W'(back_acc),
                         rdq_pkg::DATA_W'(front_val),
                         rdq_pkg::DATA_W'(rd_acc)};

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      calc_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        count      <= count_next;
        calc_valid <= 1'b1;
      end else if (out_load) begin
        calc_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      calc_kind   <= in_kind;
      calc_status <= st;
      calc_pos    <= in_pos;
    end
    if (out_load) begin
      m_tdata <= m_tdata_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    calc_valid |-> !s_tready)
    else $error("input taken while an item is in work");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (in_kind == rdq_pkg::KIND_PUSH_BACK ||
                        in_kind == rdq_pkg::KIND_PUSH_FRONT)) |=> $stable(count))
    else $error("rejected push changed the fill count");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (in_kind == rdq_pkg::KIND_POP_FRONT ||
                         in_kind == rdq_pkg::KIND_POP_BACK)) |=> (count == '0))
    else $error("rejected pop changed the fill count");

  a_result_after_item: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && !calc_valid)
    else $error("result not presented after gather");

endmodule

@@ hdl/rdq_cell.sv @@
// one storage cell of the deque chain
`timescale 1ns / 1ps
module rdq_cell #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                    clk,
  input  rdq_pkg::cell_ctrl_t     ctrl,
  input  logic [ELEM_WIDTH-1:0]   left,
  input  logic [ELEM_WIDTH-1:0]   right,
  input  logic [ELEM_WIDTH-1:0]   din,
  output logic [ELEM_WIDTH-1:0]   q
);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      rdq_pkg::CELL_HOLD: q <= q;
      rdq_pkg::CELL_SHR:  q <= left;
      rdq_pkg::CELL_SHL:  q <= right;
      rdq_pkg::CELL_LOAD: begin
        if (ctrl.hit) begin
          q <= din;
        end
      end
    endcase
  end

endmodule

@@ dv/rdq_result_checker.sv @@
// result checker for the ring deque: tracks accepted beats, predicts and compares results
`timescale 1ns / 1ps
module rdq_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [rdq_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [rdq_pkg::KIND_W-1:0]    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [rdq_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            fails,
  output int                            outstanding,
  output int                            checked,
  output int                            rejected,
  output int                            out_of_range,
  output int                            peak_fill
);

  localparam int DEPTH = 16;

  // lowest field last so the struct lines up with m_tdata
  typedef struct packed {
    rdq_pkg::status_t           status;
    logic [rdq_pkg::FILL_W-1:0] fill_count;
    logic [rdq_pkg::DATA_W-1:0] back_elem;
    logic [rdq_pkg::DATA_W-1:0] front_elem;
    logic [rdq_pkg::DATA_W-1:0] read_data;
  } deque_view_t;

  logic [rdq_pkg::DATA_W-1:0] ring [DEPTH];
  logic [rdq_pkg::POS_W-1:0]  head = '0;
  logic [rdq_pkg::POS_W-1:0]  tail = '0;
  logic [rdq_pkg::FILL_W-1:0] count = '0;
  deque_view_t                awaited_results[$];

  function automatic logic [rdq_pkg::DATA_W-1:0] elem_at(logic [rdq_pkg::FILL_W-1:0] idx);
    logic [rdq_pkg::POS_W-1:0] slot;
    slot = head + idx[rdq_pkg::POS_W-1:0];
    return ring[slot];
  endfunction

  function automatic deque_view_t deque_apply(logic [rdq_pkg::KIND_W-1:0] kind,
                                              logic [rdq_pkg::DATA_W-1:0] data,
                                              logic [rdq_pkg::POS_W-1:0]  pos);
    deque_view_t v;
    v = '0;
    v.status = rdq_pkg::STAT_OK;
    case (kind)
      rdq_pkg::KIND_PUSH_BACK: begin
        if (count == DEPTH) begin
          v.status = rdq_pkg::STAT_FULL;
        end else begin
          ring[tail] = data;
          tail = tail + 1'b1;
          count = count + 1'b1;
        end
      end
      rdq_pkg::KIND_PUSH_FRONT: begin
        if (count == DEPTH) begin
          v.status = rdq_pkg::STAT_FULL;
        end else begin
          head = head - 1'b1;
          ring[head] = data;
          count = count + 1'b1;
        end
      end
      rdq_pkg::KIND_POP_FRONT: begin
        if (count == 0) begin
          v.status = rdq_pkg::STAT_EMPTY;
        end else begin
          head = head + 1'b1;
          count = count - 1'b1;
        end
      end
      rdq_pkg::KIND_POP_BACK: begin
        if (count == 0) begin
          v.status = rdq_pkg::STAT_EMPTY;
        end else begin
          tail = tail - 1'b1;
          count = count - 1'b1;
        end
      end
      rdq_pkg::KIND_READ: begin
        if (rdq_pkg::FILL_W'(pos) >= count) begin
          v.status = rdq_pkg::STAT_RANGE;
        end else begin
          v.read_data = elem_at(rdq_pkg::FILL_W'(pos));
        end
      end
      default: ;
    endcase
    if (count != 0) begin
      v.front_elem = elem_at('0);
      v.back_elem  = elem_at(count - 1'b1);
    end
    v.fill_count = count;
    return v;
  endfunction

  task automatic compare_field(string name,
                               logic [rdq_pkg::DATA_W-1:0] want_v,
                               logic [rdq_pkg::DATA_W-1:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      if (fails <= 10) begin
        $display("result %0d: %s expected %h, got %h", checked, name, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    deque_view_t got;
    deque_view_t want;
    if (rst) begin
      head = '0;
      tail = '0;
      count = '0;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(deque_view_t)-1:0];
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("result beat with no operation awaiting it: %h", m_tdata);
          end
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          checked++;
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("front_elem", want.front_elem, got.front_elem);
          compare_field("back_elem", want.back_elem, got.back_elem);
          compare_field("fill_count", rdq_pkg::DATA_W'(want.fill_count),
                        rdq_pkg::DATA_W'(got.fill_count));
          compare_field("status", rdq_pkg::DATA_W'(want.status),
                        rdq_pkg::DATA_W'(got.status));
          if (want.status == rdq_pkg::STAT_FULL || want.status == rdq_pkg::STAT_EMPTY) begin
            rejected++;
          end
          if (want.status == rdq_pkg::STAT_RANGE) out_of_range++;
          if (int'(want.fill_count) > peak_fill) peak_fill = want.fill_count;
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_results.insert(awaited_results.size(),
                               deque_apply(s_tuser, s_tdata[rdq_pkg::DATA_W-1:0],
                                           s_tdata[rdq_pkg::DATA_W +: rdq_pkg::POS_W]));
      end
      outstanding <= awaited_results.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// testbench top for the ring deque: clock, reset, operation stimulus and verdict
`timescale 1ns / 1ps
module tb;

  localparam logic [rdq_pkg::KIND_W-1:0] KIND_NOP_LO = 3'd5;
  localparam logic [rdq_pkg::KIND_W-1:0] KIND_NOP_HI = 3'd7;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} mix_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [rdq_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [rdq_pkg::KIND_W-1:0]    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [rdq_pkg::M_TDATA_W-1:0] m_tdata;

  int fails;
  int outstanding;
  int checked;
  int rejected;
  int out_of_range;
  int peak_fill;
  int sent = 0;
  int choke_ask = 0;
  bit steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ring_deque_with_index_read DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rdq_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fails        (fails),
    .outstanding  (outstanding),
    .checked      (checked),
    .rejected     (rejected),
    .out_of_range (out_of_range),
    .peak_fill    (peak_fill)
  );

  task automatic offer(logic [rdq_pkg::KIND_W-1:0] kind,
                       logic [rdq_pkg::DATA_W-1:0] data,
                       logic [rdq_pkg::POS_W-1:0]  pos);
    if (!steady && $urandom_range(0, 99) < 17) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(rdq_pkg::S_TDATA_W-rdq_pkg::DATA_W-rdq_pkg::POS_W){1'b0}}, pos, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [rdq_pkg::KIND_W-1:0] pick_kind(mix_t mode);
    int r;
    int push_below;
    r = $urandom_range(0, 99);
    push_below = (mode == MODE_FILL) ? 78 : (mode == MODE_DRAIN) ? 43 : 64;
    if (r < 3) return rdq_pkg::KIND_W'($urandom_range(KIND_NOP_LO, KIND_NOP_HI));
    if (r < 28) return rdq_pkg::KIND_READ;
    if (r < push_below) begin
      return $urandom_range(0, 1) ? rdq_pkg::KIND_PUSH_BACK : rdq_pkg::KIND_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? rdq_pkg::KIND_POP_FRONT : rdq_pkg::KIND_POP_BACK;
  endfunction

  function automatic logic [rdq_pkg::DATA_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // receiver side, with one long hold-off on request
  initial begin
    int hold_left;
    int chokes_seen;
    hold_left = 0;
    chokes_seen = 0;
    forever begin
      @(posedge clk);
      if (choke_ask != chokes_seen) begin
        chokes_seen = choke_ask;
        hold_left = 90;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (steady) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("ring_deque_with_index_read verification failed");
    $finish;
  end

  initial begin
    mix_t mode;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty deque, ignored kinds, then fill to full and reject
    offer(rdq_pkg::KIND_POP_FRONT, '1, '1);
    offer(rdq_pkg::KIND_POP_BACK, '1, '1);
    offer(rdq_pkg::KIND_READ, '0, '0);
    offer(KIND_NOP_LO, '1, '1);
    offer(KIND_NOP_HI, '0, '0);
    offer(rdq_pkg::KIND_PUSH_BACK, '1, '0);
    offer(rdq_pkg::KIND_PUSH_FRONT, '0, '1);
    offer(rdq_pkg::KIND_READ, $urandom, 4'd1);
    offer(rdq_pkg::KIND_READ, $urandom, 4'd2);
    for (int i = 0; i < 14; i++) begin
      offer(i[0] ? rdq_pkg::KIND_PUSH_FRONT : rdq_pkg::KIND_PUSH_BACK, $urandom,
            rdq_pkg::POS_W'($urandom_range(0, 15)));
    end
    offer(rdq_pkg::KIND_PUSH_BACK, $urandom, '0);
    offer(rdq_pkg::KIND_PUSH_FRONT, $urandom, '0);
    offer(rdq_pkg::KIND_READ, $urandom, '1);
    offer(rdq_pkg::KIND_POP_FRONT, $urandom, '0);
    offer(rdq_pkg::KIND_POP_BACK, $urandom, '0);
    drain();

    for (int blk = 0; blk < 16; blk++) begin
      steady = (blk == 4 || blk == 7);
      case (blk % 3)
        0: mode = MODE_FILL;
        1: mode = MODE_MIX;
        default: mode = MODE_DRAIN;
      endcase
      if (blk == 7) begin
        mode = MODE_FILL;
        choke_ask <= choke_ask + 1;
      end
      if (blk == 10) drain();
      for (int i = 0; i < 38; i++) begin
        offer(pick_kind(mode), pick_data(), rdq_pkg::POS_W'($urandom_range(0, 15)));
      end
    end
    steady = 1'b0;

    drain();
    repeat (6) @(posedge clk);
    $display("sent %0d operations, checked %0d results: %0d rejected pushes or pops,",
             sent, checked, rejected);
    $display("%0d reads past the fill, fill reached %0d of 16, long output stall and input pause",
             out_of_range, peak_fill);
    if (fails == 0) begin
      $display("ring_deque_with_index_read verification clean");
    end else begin
      $display("ring_deque_with_index_read verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rdq_pkg.sv
hdl/rdq_cell.sv
hdl/ring_deque_with_index_read.sv
dv/rdq_result_checker.sv
dv/tb.sv
